[sv/cwd_pkg.sv]
// Shared types and constants of the CRC-checked word deframer.
package cwd_pkg;

    // Longest response, in data words, and the width of the word counter.
    localparam int MAX_WORDS  = 2;
    localparam int WORD_CNT_W = $clog2(MAX_WORDS + 1);

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int WORDS_W    = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_CRC_POLY  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRC_START = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WORDS     = 2'd2;

    localparam logic [7:0]         CRC_POLY_RST  = 8'h31;
    localparam logic [7:0]         CRC_START_RST = 8'hFF;
    localparam logic [WORDS_W-1:0] WORDS_RST     = 2'd2;

    // Word status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
    localparam logic [1:0] STATUS_SKIPPED = 2'd2;

    typedef struct packed {
        logic [7:0]         crc_poly;
        logic [7:0]         crc_start;
        logic [WORDS_W-1:0] words;
    } t_cfg;

endpackage

[sv/cwd_cfg_regs.sv]
// Configuration registers of the word deframer.
module cwd_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cwd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [cwd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output cwd_pkg::t_cfg                   o_cfg
);
    import cwd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_poly  <= CRC_POLY_RST;
            r_cfg.crc_start <= CRC_START_RST;
            r_cfg.words     <= WORDS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CRC_POLY:  r_cfg.crc_poly  <= i_cfg_wdata[7:0];
                CFG_CRC_START: r_cfg.crc_start <= i_cfg_wdata[7:0];
                CFG_WORDS:     r_cfg.words     <= i_cfg_wdata[WORDS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[sv/cwd_crc8.sv]
// Byte-wide MSB-first CRC-8 update, unrolled over the eight bit steps.
module cwd_crc8 (
    input  logic [7:0] i_crc,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_poly,
    output logic [7:0] o_crc
);
    logic [7:0] v;

    always_comb begin
        v = i_crc ^ i_byte;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ i_poly;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
    end

    assign o_crc = v;

endmodule

[sv/cwd_core.sv]
// Framing state, CRC check and result register of the word deframer.
module cwd_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cwd_pkg::t_cfg i_cfg,
    input  logic          i_item_valid,
    input  logic [7:0]    i_item_byte,
    input  logic          i_item_start,
    output logic          o_item_take,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [15:0]   o_out_word,
    output logic [1:0]    o_out_status,
    output logic          o_out_last
);
    import cwd_pkg::*;

    typedef enum logic [1:0] {
        POS_HIGH,
        POS_LOW,
        POS_CRC
    } t_pos;

    t_pos                  r_pos;
    logic [WORD_CNT_W-1:0] r_cnt;
    logic                  r_mis;
    logic [7:0]            r_high;
    logic [7:0]            r_low;
    logic [7:0]            r_crc;
    logic                  r_out_valid;
    logic [15:0]           r_out_word;
    logic [1:0]            r_out_status;
    logic                  r_out_last;

    t_pos                  n_pos;
    logic [WORD_CNT_W-1:0] n_cnt;
    logic                  n_mis;
    logic [7:0]            n_high;
    logic [7:0]            n_low;
    logic [7:0]            n_crc;
    logic                  n_out_valid;
    logic [15:0]           n_out_word;
    logic [1:0]            n_out_status;
    logic                  n_out_last;

    t_pos                  w_pos;
    logic [WORD_CNT_W-1:0] w_cnt;
    logic                  w_mis;
    logic [WORD_CNT_W-1:0] w_total;
    logic                  w_active;
    logic                  w_take;
    logic                  w_result;
    logic [1:0]            w_status;
    logic [7:0]            w_crc_in;
    logic [7:0]            w_crc_out;

    // Effective word count: zero acts as one, larger values saturate.
    always_comb begin
        if (i_cfg.words == '0) begin
            w_total = WORD_CNT_W'(1);
        end else if (int'(i_cfg.words) > MAX_WORDS) begin
            w_total = WORD_CNT_W'(MAX_WORDS);
        end else begin
            w_total = WORD_CNT_W'(i_cfg.words);
        end
    end

    // A start mark restarts the response before the byte is used.
    assign w_pos    = i_item_start ? POS_HIGH : r_pos;
    assign w_cnt    = i_item_start ? '0 : r_cnt;
    assign w_mis    = i_item_start ? 1'b0 : r_mis;
    assign w_active = (w_cnt < w_total);

    assign w_take   = i_item_valid && (!r_out_valid || i_out_ready);
    assign w_result = w_take && w_active && (w_pos == POS_CRC);

    assign w_crc_in = (w_pos == POS_HIGH) ? i_cfg.crc_start : r_crc;

    cwd_crc8 u_crc8 (
        .i_crc  (w_crc_in),
        .i_byte (i_item_byte),
        .i_poly (i_cfg.crc_poly),
        .o_crc  (w_crc_out)
    );

    always_comb begin
        if (w_mis) begin
            w_status = STATUS_SKIPPED;
        end else if (r_crc != i_item_byte) begin
            w_status = STATUS_CRC_ERR;
        end else begin
            w_status = STATUS_OK;
        end
    end

    // Next state: a taken byte advances the framing; a result leaves when it is accepted.
    always_comb begin
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_mis        = r_mis;
        n_high       = r_high;
        n_low        = r_low;
        n_crc        = r_crc;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_word   = r_out_word;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        if (w_take) begin
            n_pos = w_pos;
            n_cnt = w_cnt;
            n_mis = w_mis;
            if (w_active) begin
                unique case (w_pos)
                    POS_HIGH: begin
                        n_high = i_item_byte;
                        n_crc  = w_crc_out;
                        n_pos  = POS_LOW;
                    end
                    POS_LOW: begin
                        n_low = i_item_byte;
                        n_crc = w_crc_out;
                        n_pos = POS_CRC;
                    end
                    POS_CRC: begin
                        n_out_valid  = 1'b1;
                        n_out_word   = {r_high, r_low};
                        n_out_status = w_status;
                        n_out_last   = ((w_cnt + 1'b1) == w_total);
                        n_mis        = w_mis || (w_status == STATUS_CRC_ERR);
                        n_cnt        = w_cnt + 1'b1;
                        n_pos        = POS_HIGH;
                        n_crc        = i_cfg.crc_start;
                    end
                    default: begin
                        n_pos = POS_HIGH;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= POS_HIGH;
            r_cnt        <= '0;
            r_mis        <= 1'b0;
            r_high       <= '0;
            r_low        <= '0;
            r_crc        <= CRC_START_RST;
            r_out_valid  <= 1'b0;
            r_out_word   <= '0;
            r_out_status <= STATUS_OK;
            r_out_last   <= 1'b0;
        end else begin
            r_pos        <= n_pos;
            r_cnt        <= n_cnt;
            r_mis        <= n_mis;
            r_high       <= n_high;
            r_low        <= n_low;
            r_crc        <= n_crc;
            r_out_valid  <= n_out_valid;
            r_out_word   <= n_out_word;
            r_out_status <= n_out_status;
            r_out_last   <= n_out_last;
        end
    end

    assign o_item_take  = w_take;
    assign o_out_valid  = r_out_valid;
    assign o_out_word   = r_out_word;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= MAX_WORDS)
        else $error("word counter beyond the longest response");

    a_err_sets_mis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_result && w_status == STATUS_CRC_ERR) |=> r_mis)
        else $error("CRC mismatch did not mark the response");

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result |=> (r_out_valid && r_pos == POS_HIGH))
        else $error("CRC byte did not produce a result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status == STATUS_OK || r_out_status == STATUS_CRC_ERR
                         || r_out_status == STATUS_SKIPPED))
        else $error("undefined word status code");
`endif

endmodule

[sv/crc_checked_word_deframer.sv]
// Top level of the CRC-checked word deframer: input register, configuration and core.
// A result is registered: its CRC byte is checked out of the input register straight into the
// result register.
// Throughput: one byte per cycle while results are accepted; the core's single pass sets this rate.
// The input register refills in the cycle it empties, so a stalled result only holds the byte stream
// once both the input register and the result register are full.
// Reset (synchronous, active low) clears all valid flags, returns framing to the first byte of a
// response and loads the configuration registers with their default values.
module crc_checked_word_deframer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [cwd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [cwd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Received byte stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]                      s_axis_tuser,   // [0] starts_response
    // Word results.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,   // [15:0] data_word
    output logic [1:0]                      m_axis_tuser,   // [1:0] word_status
    output logic                            m_axis_tlast    // last_word
);
    import cwd_pkg::*;

    t_cfg       w_cfg;
    logic       w_take;

    // Input register: holds one byte until the core takes it.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_start;

    cwd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // A new item is taken whenever the register is empty or is being emptied.
    assign s_axis_tready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= s_axis_tdata;
                r_in_start <= s_axis_tuser[0];
            end else if (w_take) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    cwd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_item_valid (r_in_valid),
        .i_item_byte  (r_in_byte),
        .i_item_start (r_in_start),
        .o_item_take  (w_take),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_word   (m_axis_tdata),
        .o_out_status (m_axis_tuser),
        .o_out_last   (m_axis_tlast)
    );

endmodule

[dv/crc_word_checker.sv]
// Checker of the word deframer: predicts each word result from the byte stream and compares.
`timescale 1ns / 100ps

module crc_word_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cwd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [cwd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_in_start,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [15:0]                     i_out_word,
    input  logic [1:0]                      i_out_status,
    input  logic                            i_out_last,
    output int                              o_fail_count,
    output int                              o_pending
);
    import cwd_pkg::*;

    typedef enum logic [1:0] {
        POS_HIGH = 2'd0,
        POS_LOW  = 2'd1,
        POS_CRC  = 2'd2
    } t_byte_pos;

    typedef struct packed {
        logic [15:0] word;
        logic [1:0]  status;
        logic        last;
    } t_word_result;

    t_cfg           cfg;
    t_byte_pos      byte_pos;
    logic [7:0]     high_byte;
    logic [7:0]     low_byte;
    logic [7:0]     crc_acc;
    logic [1:0]     word_idx;
    logic           crc_bad_seen;
    t_word_result   expected_words[$];
    int             fails;

    // Byte-wide update of an MSB-first CRC-8.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data,
                                               input logic [7:0] poly);
        logic [7:0] v;
        v = crc ^ data;
        for (int b = 0; b < 8; b++)
            v = v[7] ? ((v << 1) ^ poly) : (v << 1);
        return v;
    endfunction

    // Word count of a response, with 0 acting as 1 and values above the maximum saturated.
    function automatic int unsigned words_in_response(input logic [WORDS_W-1:0] w);
        if (w < 1)
            return 1;
        if (w > MAX_WORDS)
            return MAX_WORDS;
        return 32'(w);
    endfunction

    task automatic predict_byte(input logic [7:0] data, input logic start);
        int unsigned  total;
        t_word_result r;
        total = words_in_response(cfg.words);
        if (start) begin
            byte_pos     = POS_HIGH;
            word_idx     = '0;
            crc_bad_seen = 1'b0;
            crc_acc      = cfg.crc_start;
        end
        // Bytes past the last word of a response are ignored until the next mark.
        if (word_idx >= total)
            return;
        case (byte_pos)
            POS_HIGH: begin
                high_byte = data;
                crc_acc   = crc8_update(cfg.crc_start, data, cfg.crc_poly);
                byte_pos  = POS_LOW;
            end
            POS_LOW: begin
                low_byte = data;
                crc_acc  = crc8_update(crc_acc, data, cfg.crc_poly);
                byte_pos = POS_CRC;
            end
            default: begin
                r.word = {high_byte, low_byte};
                if (crc_bad_seen) begin
                    r.status = STATUS_SKIPPED;
                end else if (crc_acc != data) begin
                    r.status     = STATUS_CRC_ERR;
                    crc_bad_seen = 1'b1;
                end else begin
                    r.status = STATUS_OK;
                end
                r.last = (word_idx + 1 == total);
                expected_words.push_back(r);
                word_idx = word_idx + 2'd1;
                byte_pos = POS_HIGH;
                crc_acc  = cfg.crc_start;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_word_result exp_word;
        if (!i_rst_n) begin
            cfg          = '{crc_poly: CRC_POLY_RST, crc_start: CRC_START_RST, words: WORDS_RST};
            byte_pos     = POS_HIGH;
            high_byte    = '0;
            low_byte     = '0;
            crc_acc      = CRC_START_RST;
            word_idx     = '0;
            crc_bad_seen = 1'b0;
            expected_words.delete();
        end else begin
            // Results first: a word can never leave in the cycle its CRC byte enters.
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word: expected none, got word %h status %0d last %0b",
                             $time, i_out_word, i_out_status, i_out_last);
                    fails++;
                end else begin
                    exp_word = expected_words.pop_front();
                    if (i_out_word !== exp_word.word) begin
                        $display("%0t: data_word mismatch: expected %h, got %h",
                                 $time, exp_word.word, i_out_word);
                        fails++;
                    end
                    if (i_out_status !== exp_word.status) begin
                        $display("%0t: word_status mismatch: expected %0d, got %0d",
                                 $time, exp_word.status, i_out_status);
                        fails++;
                    end
                    if (i_out_last !== exp_word.last) begin
                        $display("%0t: last_word mismatch: expected %0b, got %0b",
                                 $time, exp_word.last, i_out_last);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_CRC_POLY:  cfg.crc_poly  = i_cfg_wdata[7:0];
                    CFG_CRC_START: cfg.crc_start = i_cfg_wdata[7:0];
                    CFG_WORDS:     cfg.words     = i_cfg_wdata[WORDS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_byte(i_in_byte, i_in_start);
        end
        o_fail_count = fails;
        o_pending    = expected_words.size();
    end

endmodule

[dv/tb.sv]
// Top of the word deframer testbench: clock, reset, byte and configuration stimulus, verdict.
`timescale 1ns / 100ps

module tb;
    import cwd_pkg::*;

    // Random items per configuration phase; eight phases give roughly 1850 items.
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 232;
    // Length of the long receiver hold-off, and the quiet-cycle limit of the watchdog.
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_LIMIT     = 5000;
    // Margin for the input and result registers to drain, waited out before registers are rewritten.
    localparam int SETTLE_CYCLES   = 6;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] rx_byte
    logic [0:0]             s_axis_tuser;   // [0] starts_response
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [15:0]            m_axis_tdata;   // [15:0] data_word
    logic [1:0]             m_axis_tuser;   // [1:0] word_status
    logic                   m_axis_tlast;

    int fail_count;
    int pending_words;

    // Idling percentages of the current phase, and the request for a long receiver hold-off.
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;

    // The testbench's own copy of the configuration, used only to build well-formed frames.
    logic [7:0]         poly_now;
    logic [7:0]         start_now;
    logic [WORDS_W-1:0] words_now;

    int items_sent;
    int quiet_cycles;

    crc_checked_word_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    crc_word_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_in_start   (s_axis_tuser[0]),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_word   (m_axis_tdata),
        .i_out_status (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // The watchdog counts cycles in which neither side moves an item. Only a hung block
    // reaches the limit: the longest hold-off and the settling pauses are far shorter.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles at %0t", quiet_cycles, $time);
            $display("tb failed");
            $finish;
        end
    end

    // The receiver stalls at random at each falling edge. When a hold-off is requested it
    // keeps tready low for a long stretch, counted here, so that the deframer fills up and
    // has to push back on the byte stream.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request  = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // CRC of one word as the sender would compute it, with the current configuration.
    function automatic logic [7:0] frame_crc(input logic [7:0] high_b, input logic [7:0] low_b);
        logic [7:0] v;
        v = start_now ^ high_b;
        for (int b = 0; b < 8; b++)
            v = v[7] ? ((v << 1) ^ poly_now) : (v << 1);
        v = v ^ low_b;
        for (int b = 0; b < 8; b++)
            v = v[7] ? ((v << 1) ^ poly_now) : (v << 1);
        return v;
    endfunction

    // Offers one byte and returns at the falling edge after it has been accepted. The valid
    // flag stays high on return, so back-to-back items need no change to it at all.
    task automatic send_byte(input logic [7:0] data, input logic start, input bit counted);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid   = 1'b1;
        s_axis_tdata    = data;
        s_axis_tuser[0] = start;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (counted)
            items_sent++;
    endtask

    // Sends one group of three bytes; a non-zero mask corrupts the CRC byte.
    task automatic send_word(input logic [7:0] high_b, input logic [7:0] low_b,
                             input logic start, input logic [7:0] crc_mask);
        send_byte(high_b, start, 1'b1);
        send_byte(low_b, 1'b0, 1'b1);
        send_byte(frame_crc(high_b, low_b) ^ crc_mask, 1'b0, 1'b1);
    endtask

    // Writes one register at a falling edge; the deframer takes it at the next rising edge.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (addr)
            CFG_CRC_POLY:  poly_now  = data[7:0];
            CFG_CRC_START: start_now = data[7:0];
            CFG_WORDS:     words_now = data[WORDS_W-1:0];
            default: ;
        endcase
    endtask

    // Stops offering bytes and waits until every expected word has come out, then lets the
    // pipeline settle, since a trailing byte that gives no word may still be in flight.
    task automatic wait_idle(input int settle);
        s_axis_tvalid = 1'b0;
        while (pending_words != 0)
            @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // One random response. Most are well-formed: a marked first byte and the configured
    // number of words, with a correct CRC on most of them. The rest are stray bytes with a
    // random mark, responses cut short (sometimes inside a group) by the next mark, and
    // responses followed by bytes past their last word, which the deframer ignores.
    task automatic send_random_response();
        int         kind;
        int         n_words;
        int         n_extra;
        logic [7:0] mask;
        kind    = $urandom_range(0, 99);
        n_words = (words_now < 1) ? 1 : ((words_now > MAX_WORDS) ? MAX_WORDS : int'(words_now));
        if (kind < 10) begin
            send_byte(8'($urandom), ($urandom_range(0, 3) == 0), 1'b1);
            return;
        end
        if (kind < 20)
            n_words = $urandom_range(0, n_words - 1);
        for (int w = 0; w < n_words; w++) begin
            mask = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00;
            send_word(8'($urandom), 8'($urandom), (w == 0), mask);
        end
        if (kind < 20) begin
            // A partial group, abandoned when the next response begins.
            n_extra = $urandom_range(0, 2);
            for (int k = 0; k < n_extra; k++)
                send_byte(8'($urandom), (n_words == 0 && k == 0), 1'b1);
        end else if (kind < 30) begin
            n_extra = $urandom_range(1, 4);
            for (int k = 0; k < n_extra; k++)
                send_byte(8'($urandom), 1'b0, 1'b0);
        end
    endtask

    initial begin
        logic [7:0]         phase_poly [4];
        logic [7:0]         phase_start[4];
        logic [WORDS_W-1:0] phase_words[4];
        int                 phase_first;
        bit                 hold_done;

        // Fixed settings take each register to its extremes; later phases are random.
        phase_poly  = '{8'h31, 8'h00, 8'hFF, 8'h07};
        phase_start = '{8'hFF, 8'h00, 8'hFF, 8'h00};
        phase_words = '{2'd2, 2'd1, 2'd0, 2'd3};
        hold_done   = 1'b0;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = '0;
        i_cfg_wdata     = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_request    = 1'b0;
        poly_now        = CRC_POLY_RST;
        start_now       = CRC_START_RST;
        words_now       = WORDS_RST;
        items_sent      = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part, with the reset configuration. The first response carries no mark:
        // after reset the next byte is already the high byte of a first word.
        send_word(8'hBE, 8'hEF, 1'b0, 8'h00);
        send_word(8'h00, 8'h00, 1'b0, 8'hFF);
        // A byte past the last word gives nothing.
        send_byte(8'h55, 1'b0, 1'b1);
        // A mismatch in the first word makes the second word skipped, even with a good CRC.
        send_word(8'hFF, 8'hFF, 1'b1, 8'h01);
        send_word(8'h00, 8'h00, 1'b0, 8'h00);
        // A new mark in the middle of a group abandons that group without a word.
        send_byte(8'h12, 1'b1, 1'b1);
        send_byte(8'h34, 1'b0, 1'b1);
        send_word(8'h00, 8'hFF, 1'b1, 8'h00);
        send_word(8'hFF, 8'h00, 1'b0, 8'h00);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle(SETTLE_CYCLES);
            if (p < 4) begin
                write_reg(CFG_CRC_POLY,  phase_poly[p]);
                write_reg(CFG_CRC_START, phase_start[p]);
                write_reg(CFG_WORDS,     {6'($urandom), phase_words[p]});
            end else begin
                write_reg(CFG_CRC_POLY,  8'($urandom));
                write_reg(CFG_CRC_START, 8'($urandom));
                write_reg(CFG_WORDS,     8'($urandom));
            end
            // Idling modes in turn: none, sender idle, receiver stalling, both.
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            phase_first = items_sent;
            while (items_sent - phase_first < ITEMS_PER_PHASE) begin
                // In the first phase the sender never idles, so a long hold-off fills the
                // deframer and stalls its input.
                if (p == 0 && !hold_done && items_sent - phase_first >= 60) begin
                    hold_request = 1'b1;
                    hold_done    = 1'b1;
                end
                send_random_response();
            end
        end

        wait_idle(10);
        if (fail_count == 0 && pending_words == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
